/* sv/tcw_pkg.sv */
// Shared constants, command codes and controller/datapath interface structs
// for the text console writer. No dependencies.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int ADDR_W = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

  localparam logic [0:0] REG_TEXT_COLOR = 1'b0;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic cnt_clr;
    logic cnt_inc;
    logic fill_we;
    logic fill_reset_color;
    logic copy_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic need_scroll;
    logic fill_end;
    logic copy_end;
    logic out_busy;
  } dp_status_t;

endpackage

/* sv/tcw_ctrl.sv */
// Sequencing state machine for the text console writer.
// Depends on tcw_pkg for command codes and the command/status structs.
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcw_pkg::dp_status_t status,
  output tcw_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_EXEC  = 8'b0000_0100,
    ST_FILL  = 8'b0000_1000,
    ST_COPY  = 8'b0001_0000,
    ST_DRAIN = 8'b0010_0000,
    ST_BLANK = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.fill_we          = 1'b1;
        cmd.fill_reset_color = 1'b1;
        cmd.cnt_inc          = 1'b1;
        if (status.fill_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec    = 1'b1;
        cmd.cnt_clr = 1'b1;
        unique case (status.cmd)
          tcw_pkg::CMD_PUT: begin
            state_nxt = status.need_scroll ? ST_COPY : ST_DONE;
          end
          tcw_pkg::CMD_CLEAR: begin
            state_nxt = ST_FILL;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_FILL: begin
        cmd.fill_we = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status.fill_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (status.copy_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_BLANK;
      end
      ST_BLANK: begin
        cmd.fill_we = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status.fill_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

/* sv/tcw_datapath.sv */
// Cell store, cursor, sweep counter and result register of the console writer.
// Depends on tcw_pkg; driven by tcw_ctrl through ctrl_cmd_t.
module tcw_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcw_pkg::ctrl_cmd_t         cmd,
  output tcw_pkg::dp_status_t        status,
  input  logic [tcw_pkg::CHAR_W-1:0] text_color,
  input  logic [1:0]                 in_command,
  input  logic [tcw_pkg::CHAR_W-1:0] in_character,
  input  logic [tcw_pkg::COL_W-1:0]  in_column,
  input  logic [tcw_pkg::ROW_W-1:0]  in_row,
  input  logic [tcw_pkg::CHAR_W-1:0] in_cell_color,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tcw_pkg::ADDR_W-1:0] out_cursor_position,
  output logic [tcw_pkg::CELL_W-1:0] out_cell_value
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int CW = tcw_pkg::COL_W;
  localparam logic [AW-1:0] COLS_A     = AW'(tcw_pkg::COLUMNS);
  localparam logic [CW-1:0] COLS_C     = CW'(tcw_pkg::COLUMNS);
  localparam logic [AW-1:0] FILL_LAST  = AW'(tcw_pkg::CELL_COUNT - 1);
  localparam logic [AW-1:0] COPY_LAST  = AW'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS - 1);
  localparam logic [7:0]    COLS_8     = 8'(tcw_pkg::COLUMNS);
  localparam logic [5:0]    ROWS_6     = 6'(tcw_pkg::ROWS);
  localparam logic [7:0]    TAB_8      = 8'(tcw_pkg::TAB_STOP);

  tcw_pkg::cmd_t                cmd_r;
  logic [tcw_pkg::CHAR_W-1:0]   ch_r;
  logic [tcw_pkg::COL_W-1:0]    col_r;
  logic [tcw_pkg::ROW_W-1:0]    row_r;
  logic [tcw_pkg::CHAR_W-1:0]   attr_r;
  logic [tcw_pkg::COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [tcw_pkg::ROW_W-1:0]    cur_row_r, cur_row_nxt;
  logic [AW-1:0]                cnt_r;
  logic                         pend_r;
  logic [AW-1:0]                waddr_r;
  logic [tcw_pkg::CELL_W-1:0]   rdata_r;
  logic                         out_valid_r;
  logic [AW-1:0]                out_pos_r;
  logic [tcw_pkg::CELL_W-1:0]   out_val_r;
  logic [tcw_pkg::CELL_W-1:0]   mem_r [tcw_pkg::CELL_COUNT];

  logic                         in_range;
  logic [AW-1:0]                in_addr, cur_addr;
  logic                         printable;
  logic [7:0]                   col_a;
  logic [5:0]                   row_a;
  logic                         scroll;
  logic                         we, re;
  logic [AW-1:0]                wa, ra;
  logic [tcw_pkg::CELL_W-1:0]   wd;
  logic [tcw_pkg::CHAR_W-1:0]   fill_color;

  assign in_range  = (col_r < COLS_C) &&
                     ({1'b0, row_r} < ROWS_6);
  assign in_addr   = AW'(row_r) * COLS_A + AW'(col_r);
  assign cur_addr  = AW'(cur_row_r) * COLS_A + AW'(cur_col_r);
  assign printable = (ch_r != tcw_pkg::CH_NEWLINE) && (ch_r != tcw_pkg::CH_RETURN) &&
                     (ch_r != tcw_pkg::CH_BACKSPACE) && (ch_r != tcw_pkg::CH_TAB);

  // cursor motion for put-character
  always_comb begin
    col_a  = {1'b0, cur_col_r};
    row_a  = {1'b0, cur_row_r};
    scroll = 1'b0;
    priority if (ch_r == tcw_pkg::CH_NEWLINE) begin
      col_a = '0;
      row_a = row_a + 6'd1;
    end else if (ch_r == tcw_pkg::CH_RETURN) begin
      col_a = '0;
    end else if (ch_r == tcw_pkg::CH_BACKSPACE) begin
      if (col_a != 8'd0) begin
        col_a = col_a - 8'd1;
      end
    end else if (ch_r == tcw_pkg::CH_TAB) begin
      col_a = (col_a & ~(TAB_8 - 8'd1)) + TAB_8;
    end else begin
      col_a = col_a + 8'd1;
    end
    if (col_a >= COLS_8) begin
      col_a = '0;
      row_a = row_a + 6'd1;
    end
    if (row_a >= ROWS_6) begin
      row_a  = ROWS_6 - 6'd1;
      scroll = 1'b1;
    end
  end

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (cmd.exec && (cmd_r == tcw_pkg::CMD_PUT)) begin
      cur_col_nxt = col_a[tcw_pkg::COL_W-1:0];
      cur_row_nxt = row_a[tcw_pkg::ROW_W-1:0];
    end else if (cmd.exec && (cmd_r == tcw_pkg::CMD_CLEAR)) begin
      cur_col_nxt = '0;
      cur_row_nxt = '0;
    end
  end

  assign fill_color = cmd.fill_reset_color ? tcw_pkg::RESET_COLOR : text_color;

  // single write port: copy drain, sweep, or command write
  always_comb begin
    we = 1'b0;
    wa = cnt_r;
    wd = {fill_color, tcw_pkg::BLANK_CHAR};
    priority if (pend_r) begin
      we = 1'b1;
      wa = waddr_r;
      wd = rdata_r;
    end else if (cmd.fill_we) begin
      we = 1'b1;
    end else if (cmd.exec && (cmd_r == tcw_pkg::CMD_PUT) && printable) begin
      we = 1'b1;
      wa = cur_addr;
      wd = {text_color, ch_r};
    end else if (cmd.exec && (cmd_r == tcw_pkg::CMD_WRITE) && in_range) begin
      we = 1'b1;
      wa = in_addr;
      wd = {attr_r, ch_r};
    end
  end

  assign re = cmd.copy_step || (cmd.exec && (cmd_r == tcw_pkg::CMD_READ) && in_range);
  assign ra = cmd.copy_step ? (cnt_r + COLS_A) : in_addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem_r[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= tcw_pkg::cmd_t'(in_command);
      ch_r   <= in_character;
      col_r  <= in_column;
      row_r  <= in_row;
      attr_r <= in_cell_color;
    end
    if (cmd.copy_step) begin
      waddr_r <= cnt_r;
    end
    if (cmd.out_load) begin
      out_pos_r <= cur_addr;
      out_val_r <= ((cmd_r == tcw_pkg::CMD_READ) && in_range) ? rdata_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      pend_r    <= cmd.copy_step;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + AW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.cmd         = cmd_r;
  assign status.need_scroll = scroll;
  assign status.fill_end    = (cnt_r == FILL_LAST);
  assign status.copy_end    = (cnt_r == COPY_LAST);
  assign status.out_busy    = out_valid_r && !out_ready;

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_cell_value      = out_val_r;

endmodule

/* sv/text_console_writer.sv */
// Top level of the text console writer: configuration register and APB decode,
// controller and datapath. Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// Input channel (in_valid/in_ready) takes one command beat: put character,
// write cell, clear and home, or read cell. Each beat yields exactly one
// result beat on the out_ channel with the cursor position after the command
// and, for a read, the cell value.
// Put character, write and read run an exec step and a result load; a put
// character that runs off the bottom scrolls: exec, copy of rows up, drain,
// blank of the bottom row, load. Clear runs exec, a fill of all 2000 cells,
// then load. These sweeps go through the single write port of the 2000-cell
// store; one command is worked at a time, so a new command beat is taken only
// after the last one has loaded its result.
// Reset: a clearing pass writes 0x0720 to all 2000 cells, one a cycle, with
// in_ready low; configuration writes are taken during it.
// Stall: a finished result holds in the output register while out_ready is
// low; the next command is still accepted, and its result waits behind it.
// APB: text_color at byte address 0, writable and readable, pready always high.
module text_console_writer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_command,
  input  logic [tcw_pkg::CHAR_W-1:0] in_character,
  input  logic [tcw_pkg::COL_W-1:0]  in_column,
  input  logic [tcw_pkg::ROW_W-1:0]  in_row,
  input  logic [tcw_pkg::CHAR_W-1:0] in_cell_color,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tcw_pkg::ADDR_W-1:0] out_cursor_position,
  output logic [tcw_pkg::CELL_W-1:0] out_cell_value,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [2:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  logic [tcw_pkg::CHAR_W-1:0] color_r;
  logic                       reg_hit;
  tcw_pkg::ctrl_cmd_t         cmd;
  tcw_pkg::dp_status_t        status;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[2] == tcw_pkg::REG_TEXT_COLOR);
  assign cfg_prdata = reg_hit ? {24'd0, color_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= tcw_pkg::RESET_COLOR;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      color_r <= cfg_pwdata[tcw_pkg::CHAR_W-1:0];
    end
  end

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcw_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .text_color          (color_r),
    .in_command          (in_command),
    .in_character        (in_character),
    .in_column           (in_column),
    .in_row              (in_row),
    .in_cell_color       (in_cell_color),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cursor_position (out_cursor_position),
    .out_cell_value      (out_cell_value)
  );

endmodule

/* test/tb_top.sv */
// Self-checking bench for text_console_writer: console commands with random
// handshake gaps, predicted on a shadow screen. Depends on tcw_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    tcw_pkg::cmd_t                command;
    logic [tcw_pkg::CHAR_W-1:0]   character;
    logic [tcw_pkg::COL_W-1:0]    column;
    logic [tcw_pkg::ROW_W-1:0]    row;
    logic [tcw_pkg::CHAR_W-1:0]   cell_color;
  } console_cmd_t;

  typedef struct packed {
    logic [tcw_pkg::ADDR_W-1:0] cursor_position;
    logic [tcw_pkg::CELL_W-1:0] cell_value;
  } console_view_t;

  typedef struct packed {
    console_cmd_t  item;
    console_view_t view;
  } console_beat_t;

  localparam logic [2:0] COLOR_ADDR = 3'(tcw_pkg::REG_TEXT_COLOR) << 2;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [1:0]                   in_command = tcw_pkg::CMD_PUT;
  logic [tcw_pkg::CHAR_W-1:0]   in_character = '0;
  logic [tcw_pkg::COL_W-1:0]    in_column = '0;
  logic [tcw_pkg::ROW_W-1:0]    in_row = '0;
  logic [tcw_pkg::CHAR_W-1:0]   in_cell_color = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [tcw_pkg::ADDR_W-1:0]   out_cursor_position;
  logic [tcw_pkg::CELL_W-1:0]   out_cell_value;
  logic                         cfg_psel = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite = 1'b0;
  logic [2:0]                   cfg_paddr = '0;
  logic [31:0]                  cfg_pwdata = '0;
  logic [31:0]                  cfg_prdata;
  logic                         cfg_pready;

  // shadow console
  logic [tcw_pkg::CELL_W-1:0]   screen_shadow [tcw_pkg::CELL_COUNT];
  int                           cur_row;
  int                           cur_col;
  logic [tcw_pkg::CHAR_W-1:0]   text_color;
  int                           slow_left;

  console_beat_t                beats_pending[$];
  console_view_t                views_due[$];
  console_view_t                view_in_flight;
  console_beat_t                next_beat;
  console_view_t                view_seen;
  int                           beats_in;
  int                           beats_made;
  int                           beats_checked;
  int                           mismatches;
  logic                         calm;

  assign calm = (beats_in >= 700 && beats_in < 950);

  text_console_writer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_character        (in_character),
    .in_column           (in_column),
    .in_row              (in_row),
    .in_cell_color       (in_cell_color),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cursor_position (out_cursor_position),
    .out_cell_value      (out_cell_value),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic console_view_t console_step(console_cmd_t it);
    console_view_t v;
    logic          on_screen;
    v.cell_value = '0;
    on_screen = (it.column < tcw_pkg::COLUMNS) && (it.row < tcw_pkg::ROWS);
    case (it.command)
      tcw_pkg::CMD_PUT: begin
        if (it.character == tcw_pkg::CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (it.character == tcw_pkg::CH_RETURN) begin
          cur_col = 0;
        end else if (it.character == tcw_pkg::CH_BACKSPACE) begin
          if (cur_col > 0) cur_col--;
        end else if (it.character == tcw_pkg::CH_TAB) begin
          cur_col = cur_col + tcw_pkg::TAB_STOP - (cur_col % tcw_pkg::TAB_STOP);
        end else begin
          screen_shadow[cur_row * tcw_pkg::COLUMNS + cur_col] = {text_color, it.character};
          cur_col++;
        end
        if (cur_col >= tcw_pkg::COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= tcw_pkg::ROWS) begin
          for (int i = 0; i < tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i++)
            screen_shadow[i] = screen_shadow[i + tcw_pkg::COLUMNS];
          for (int i = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i < tcw_pkg::CELL_COUNT; i++)
            screen_shadow[i] = {text_color, tcw_pkg::BLANK_CHAR};
          cur_row = tcw_pkg::ROWS - 1;
        end
      end
      tcw_pkg::CMD_WRITE: begin
        if (on_screen)
          screen_shadow[it.row * tcw_pkg::COLUMNS + it.column] =
            {it.cell_color, it.character};
      end
      tcw_pkg::CMD_CLEAR: begin
        for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
          screen_shadow[i] = {text_color, tcw_pkg::BLANK_CHAR};
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
        if (on_screen)
          v.cell_value = screen_shadow[it.row * tcw_pkg::COLUMNS + it.column];
      end
    endcase
    v.cursor_position = tcw_pkg::ADDR_W'(cur_row * tcw_pkg::COLUMNS + cur_col);
    return v;
  endfunction

  function automatic logic [tcw_pkg::COL_W-1:0] pick_column();
    return ($urandom_range(0, 99) < 80)
             ? tcw_pkg::COL_W'($urandom_range(0, tcw_pkg::COLUMNS - 1))
             : tcw_pkg::COL_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [tcw_pkg::ROW_W-1:0] pick_row();
    return ($urandom_range(0, 99) < 80)
             ? tcw_pkg::ROW_W'($urandom_range(0, tcw_pkg::ROWS - 1))
             : tcw_pkg::ROW_W'($urandom_range(0, 31));
  endfunction

  task automatic enqueue(input tcw_pkg::cmd_t cmd, input logic [tcw_pkg::CHAR_W-1:0] ch,
                         input logic [tcw_pkg::COL_W-1:0] col,
                         input logic [tcw_pkg::ROW_W-1:0] row,
                         input logic [tcw_pkg::CHAR_W-1:0] attr);
    console_beat_t b;
    b.item.command    = cmd;
    b.item.character  = ch;
    b.item.column     = col;
    b.item.row        = row;
    b.item.cell_color = attr;
    b.view = console_step(b.item);
    beats_pending.push_back(b);
    beats_made++;
  endtask

  task automatic emit_char(input logic [tcw_pkg::CHAR_W-1:0] ch);
    logic ordinary;
    logic scrolls;
    ordinary = !(ch inside {tcw_pkg::CH_NEWLINE, tcw_pkg::CH_RETURN,
                            tcw_pkg::CH_BACKSPACE, tcw_pkg::CH_TAB});
    scrolls = (cur_row == tcw_pkg::ROWS - 1) &&
              (ch == tcw_pkg::CH_NEWLINE ||
               (ch == tcw_pkg::CH_TAB &&
                cur_col + tcw_pkg::TAB_STOP - (cur_col % tcw_pkg::TAB_STOP)
                  >= tcw_pkg::COLUMNS) ||
               (ordinary && cur_col == tcw_pkg::COLUMNS - 1));
    // cap the number of slow store sweeps
    if (scrolls) begin
      if (slow_left == 0) ch = tcw_pkg::CH_RETURN;
      else slow_left--;
    end
    enqueue(tcw_pkg::CMD_PUT, ch, tcw_pkg::COL_W'($urandom), tcw_pkg::ROW_W'($urandom),
            tcw_pkg::CHAR_W'($urandom));
  endtask

  task automatic fill_phase(input int n_items);
    int                         made;
    int                         roll;
    int                         len;
    int                         pick;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    made = 0;
    while (made < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 110) : $urandom_range(1, 20);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 8) ch = tcw_pkg::CH_TAB;
          else if (pick < 11) ch = tcw_pkg::CH_BACKSPACE;
          else if (pick < 85) ch = tcw_pkg::CHAR_W'($urandom_range(8'h20, 8'h7E));
          else ch = tcw_pkg::CHAR_W'($urandom_range(0, 255));
          emit_char(ch);
          made++;
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          emit_char(tcw_pkg::CH_NEWLINE);
          made++;
        end else if (pick < 9) begin
          emit_char(tcw_pkg::CH_RETURN);
          made++;
        end
      end else if (roll < 75) begin
        enqueue(tcw_pkg::CMD_WRITE, tcw_pkg::CHAR_W'($urandom), pick_column(), pick_row(),
                tcw_pkg::CHAR_W'($urandom));
        made++;
      end else if (roll < 93 || slow_left == 0) begin
        enqueue(tcw_pkg::CMD_READ, tcw_pkg::CHAR_W'($urandom), pick_column(), pick_row(),
                tcw_pkg::CHAR_W'($urandom));
        made++;
      end else begin
        slow_left--;
        enqueue(tcw_pkg::CMD_CLEAR, tcw_pkg::CHAR_W'($urandom), tcw_pkg::COL_W'($urandom),
                tcw_pkg::ROW_W'($urandom), tcw_pkg::CHAR_W'($urandom));
        made++;
      end
    end
  endtask

  task automatic write_text_color(input logic [tcw_pkg::CHAR_W-1:0] value);
    logic [31:0] readback;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= COLOR_ADDR;
    cfg_pwdata  <= {24'b0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    text_color = value;
    if (readback[tcw_pkg::CHAR_W-1:0] != value) begin
      $display("%0t: text_color readback expected %0h got %0h", $time, value,
               readback[tcw_pkg::CHAR_W-1:0]);
      mismatches++;
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (beats_checked < beats_made) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        views_due.push_back(view_in_flight);
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (beats_pending.size() > 0 && (calm || $urandom_range(0, 99) < 70)) begin
          next_beat = beats_pending.pop_front();
          view_in_flight = next_beat.view;
          in_command    <= next_beat.item.command;
          in_character  <= next_beat.item.character;
          in_column     <= next_beat.item.column;
          in_row        <= next_beat.item.row;
          in_cell_color <= next_beat.item.cell_color;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (views_due.size() == 0) begin
          $display("%0t: result beat with none due, got cursor %0d cell %0h", $time,
                   out_cursor_position, out_cell_value);
          mismatches++;
        end else begin
          view_seen = views_due.pop_front();
          beats_checked++;
          if (out_cursor_position !== view_seen.cursor_position) begin
            $display("%0t: cursor_position expected %0d got %0d", $time,
                     view_seen.cursor_position, out_cursor_position);
            mismatches++;
          end
          if (out_cell_value !== view_seen.cell_value) begin
            $display("%0t: cell_value expected %0h got %0h", $time,
                     view_seen.cell_value, out_cell_value);
            mismatches++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) < 70);
    end
  end

  initial begin
    logic [tcw_pkg::CHAR_W-1:0] palette [4];
    palette[0] = 8'hFF;
    palette[1] = 8'h00;
    palette[2] = tcw_pkg::CHAR_W'($urandom);
    palette[3] = tcw_pkg::RESET_COLOR;
    for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
      screen_shadow[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CHAR};
    cur_row = 0;
    cur_col = 0;
    text_color = tcw_pkg::RESET_COLOR;
    beats_in = 0;
    beats_made = 0;
    beats_checked = 0;
    mismatches = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 4; p++) begin
      if (p > 0) wait_idle();
      write_text_color(palette[p]);
      slow_left = 60;
      if (p == 0) begin
        enqueue(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_READ, 8'hFF, 7'(tcw_pkg::COLUMNS - 1), 5'(tcw_pkg::ROWS - 1),
                8'hFF);
        enqueue(tcw_pkg::CMD_READ, 8'h00, 7'(tcw_pkg::COLUMNS), 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_READ, 8'h00, 7'd127, 5'd31, 8'h00);
        enqueue(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'(tcw_pkg::ROWS), 8'h00);
        enqueue(tcw_pkg::CMD_WRITE, 8'hFF, 7'(tcw_pkg::COLUMNS - 1), 5'(tcw_pkg::ROWS - 1),
                8'hFF);
        enqueue(tcw_pkg::CMD_WRITE, 8'h58, 7'(tcw_pkg::COLUMNS), 5'd0, 8'h12);
        enqueue(tcw_pkg::CMD_WRITE, 8'h59, 7'd0, 5'(tcw_pkg::ROWS), 8'h34);
        enqueue(tcw_pkg::CMD_WRITE, 8'h00, 7'd0, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_READ, 8'h00, 7'(tcw_pkg::COLUMNS - 1), 5'(tcw_pkg::ROWS - 1),
                8'h00);
        enqueue(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd1, 8'h00);
        enqueue(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_PUT, 8'h41, 7'd127, 5'd31, 8'hFF);
        enqueue(tcw_pkg::CMD_PUT, 8'hFF, 7'd0, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_PUT, 8'h00, 7'd0, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_PUT, tcw_pkg::CH_RETURN, 7'd0, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_PUT, tcw_pkg::CH_BACKSPACE, 7'd0, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 7'd0, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_PUT, 8'h33, 7'd0, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 7'd0, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 7'd0, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_READ, 8'h00, 7'd1, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_CLEAR, 8'h00, 7'd0, 5'd0, 8'h00);
        enqueue(tcw_pkg::CMD_READ, 8'h00, 7'(tcw_pkg::COLUMNS - 1), 5'(tcw_pkg::ROWS - 1),
                8'h00);
        slow_left--;
      end
      fill_phase(400);
    end
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
